// File: rtl/bvire_pkg.sv
// Package for the bit vector insert/remove engine: action, status and state codes.
`default_nettype none
package bvire_pkg;

    typedef enum logic [3:0] {
        ACT_GET    = 4'd0,
        ACT_SET    = 4'd1,
        ACT_UNSET  = 4'd2,
        ACT_TOGGLE = 4'd3,
        ACT_SETALL = 4'd4,
        ACT_INVERT = 4'd5,
        ACT_REMOVE = 4'd6,
        ACT_INSERT = 4'd7,
        ACT_ANY    = 4'd8
    } action_e_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_RDONLY = 2'd2,
        STAT_CAP    = 2'd3
    } status_e_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BIT,
        S_SWEEP,
        S_LAST
    } state_e_t;

    localparam int CFG_DATA_W = 32;
    localparam int FIELD_W    = 11;

endpackage
`default_nettype wire

// File: rtl/bvire_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
`default_nettype none
module bvire_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

// File: rtl/bvire_word_unit.sv
// Word update logic: builds one new store word for the sweeping actions.
`default_nettype none
module bvire_word_unit
    import bvire_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int ADDR_W    = 5,
    parameter int CNT_W     = 12
) (
    input  wire action_e_t            op,
    input  wire logic [ADDR_W-1:0]    word_idx,
    input  wire logic [CNT_W-1:0]     pos,
    input  wire logic [CNT_W-1:0]     span,
    input  wire logic [CNT_W-1:0]     len,
    input  wire logic [CNT_W-1:0]     new_len,
    input  wire logic [WORD_BITS-1:0] old_word,
    input  wire logic [WORD_BITS-1:0] prev_word,
    input  wire logic [WORD_BITS-1:0] cur_word,
    output logic      [WORD_BITS-1:0] new_word
);

    localparam int SW = $clog2(WORD_BITS);

    // Mask of the bits of this word whose index lies below limit.
    function automatic logic [WORD_BITS-1:0] below(input logic [CNT_W-1:0] limit,
                                                   input logic [ADDR_W-1:0] w);
        logic [CNT_W-1:0] lw;
        logic [CNT_W-1:0] wx;
        lw = limit >> SW;
        wx = CNT_W'(w);
        if (lw > wx)
        begin
            below = '1;
        end
        else if (lw == wx)
        begin
            below = ~({WORD_BITS{1'b1}} << limit[SW-1:0]);
        end
        else
        begin
            below = '0;
        end
    endfunction

    logic [SW-1:0]          sb;
    logic [SW-1:0]          rsh;
    logic [2*WORD_BITS-1:0] rem_win;
    logic [2*WORD_BITS-1:0] ins_win;
    logic [CNT_W-1:0]       pos_end;
    logic [WORD_BITS-1:0]   lt_pos;
    logic [WORD_BITS-1:0]   lt_len;
    logic [WORD_BITS-1:0]   lt_new;
    logic [WORD_BITS-1:0]   lt_end;

    always_comb
    begin
        sb      = span[SW-1:0];
        rsh     = SW'(0) - sb;
        rem_win = {cur_word, prev_word} >> sb;
        ins_win = {prev_word, cur_word} >> rsh;
        pos_end = pos + span;
        lt_pos  = below(pos, word_idx);
        lt_len  = below(len, word_idx);
        lt_new  = below(new_len, word_idx);
        lt_end  = below(pos_end, word_idx);
        case (op)
            ACT_SETALL: new_word = old_word | lt_len;
            ACT_INVERT: new_word = old_word ^ lt_len;
            ACT_REMOVE: new_word = (old_word & lt_pos)
                                 | (rem_win[WORD_BITS-1:0] & ~lt_pos & lt_new);
            ACT_INSERT: new_word = (old_word & lt_pos)
                                 | (ins_win[WORD_BITS-1:0] & ~lt_end & lt_new);
            default:    new_word = old_word;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/bit_vector_insert_remove_engine.sv
// Top level of the bit vector insert/remove engine: control, store and register port.
//
//  Channel   Signals                                    Handshake
//  -------   -----------------------------------------  ------------------------------
//  command   start, action, position, span, busy        beat taken when start & !busy
//  result    done, bit_result, vec_length, status       one-cycle strobe on done
//  config    psel, penable, pwrite, paddr, pwdata,      write at psel&penable&pwrite,
//            prdata, pready                             pready tied high
//
// Rejected, out-of-range, over-capacity and no-op commands answer in the cycle
// after the beat. Get, set, unset and toggle read one store word, pass through
// the bit state, where all but get write the word back, and then register the
// result. Set-all, invert, any-set and the range moves sweep every store word
// through the dual-read RAM, one word a cycle, then finish in the last state.
// Reset clears the length, the read-only flag and the per-word valid bits, so
// the store reads as all zeros at once. The receiver cannot stall: results
// are registered and shown for exactly one cycle.
`default_nettype none
module bit_vector_insert_remove_engine
    import bvire_pkg::*;
#(
    parameter int MAX_BITS  = 1024,
    parameter int WORD_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [3:0]            action,
    input  wire logic [FIELD_W-1:0]    position,
    input  wire logic [FIELD_W-1:0]    span,
    output logic                       busy,
    output logic                       done,
    output logic                       bit_result,
    output logic [FIELD_W-1:0]         vec_length,
    output logic [1:0]                 status,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [1:0]            paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int NW  = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW  = $clog2(NW);
    localparam int SW  = $clog2(WORD_BITS);
    localparam int LW  = $clog2(MAX_BITS + 1);
    localparam int CW  = (LW > FIELD_W) ? LW : FIELD_W;
    localparam int XW  = CW + 1;
    localparam int SAW = CW + 3;

    // Byte address of the read-only register.
    localparam logic [1:0] REG_READ_ONLY = 2'd0;

    // Control and result registers.
    state_e_t        state_reg, state_next;
    action_e_t       op_reg, op_next;
    logic [XW-1:0]   pos_reg, pos_next;
    logic [XW-1:0]   span_reg, span_next;
    logic [XW-1:0]   nlen_reg, nlen_next;
    logic [LW-1:0]   len_reg, len_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic            any_reg, any_next;
    logic            ro_reg;
    logic            done_reg, done_next;
    logic            bit_reg, bit_next;
    logic [FIELD_W-1:0] out_len_reg, out_len_next;
    status_e_t       stat_reg, stat_next;

    // Read pipeline.
    logic            p_valid_reg;
    logic [AW-1:0]   p_word_reg;
    logic            a_vld_reg;
    logic            b_vld_reg;
    logic [WORD_BITS-1:0] prev_reg;
    logic [NW-1:0]   wvalid_reg;

    // Datapath nets.
    action_e_t       act;
    logic            accept;
    logic            rejected;
    logic [XW-1:0]   pos_x, span_x, len_x, pos_min;
    logic [XW-1:0]   pos_word;
    logic [XW-1:0]   reg_word;
    logic [AW-1:0]   w_issue;
    logic            down_sel;
    logic [XW-1:0]   span_sel;
    logic [XW-1:0]   sw_sel;
    logic signed [SAW-1:0] w_sel_s, sw_s, src_s;
    logic            src_ok;
    logic            sweep_rd;
    logic [AW-1:0]   a_addr, b_addr;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS-1:0] rdata_a, rdata_b;
    logic [WORD_BITS-1:0] a_word, b_word, sweep_word, bit_word;
    logic            old_bit, new_bit;

    assign act      = action_e_t'(action);
    assign accept   = start && !busy;
    assign rejected = ro_reg && (act >= ACT_SET) && (act <= ACT_INSERT);
    assign pos_x    = XW'(position);
    assign span_x   = XW'(span);
    assign len_x    = XW'(len_reg);
    assign pos_min  = (pos_x > len_x) ? len_x : pos_x;
    assign pos_word = pos_x >> SW;
    assign reg_word = pos_reg >> SW;
    assign w_issue  = (op_reg == ACT_INSERT) ? (AW'(NW - 1) - cnt_reg) : cnt_reg;

    // Source word address for the range moves. In idle the same formula, fed word
    // index -1 for remove and WORDS for insert, yields the priming read.
    assign sweep_rd = (state_reg == S_SWEEP);
    assign down_sel = sweep_rd ? (op_reg == ACT_INSERT) : (act == ACT_INSERT);
    assign span_sel = sweep_rd ? span_reg : span_x;
    assign sw_sel   = span_sel >> SW;
    assign sw_s     = $signed(SAW'(sw_sel));
    assign w_sel_s  = sweep_rd ? $signed(SAW'(w_issue))
                               : (down_sel ? $signed(SAW'(NW)) : $signed({SAW{1'b1}}));
    assign src_s    = down_sel ? (w_sel_s - sw_s - $signed(SAW'(|span_sel[SW-1:0])))
                               : (w_sel_s + sw_s + $signed(SAW'(1)));
    assign src_ok   = !src_s[SAW-1] && (src_s < $signed(SAW'(NW)));
    assign b_addr   = src_s[AW-1:0];
    assign a_addr   = sweep_rd ? w_issue : pos_word[AW-1:0];

    // Words never written since reset read as zero.
    assign a_word = a_vld_reg ? rdata_a : '0;
    assign b_word = b_vld_reg ? rdata_b : '0;

    assign old_bit = a_word[pos_reg[SW-1:0]];
    always_comb
    begin
        case (op_reg)
            ACT_SET:    new_bit = 1'b1;
            ACT_UNSET:  new_bit = 1'b0;
            ACT_TOGGLE: new_bit = !old_bit;
            default:    new_bit = old_bit;
        endcase
        bit_word = a_word;
        bit_word[pos_reg[SW-1:0]] = new_bit;
    end

    bvire_word_unit #(
        .WORD_BITS (WORD_BITS),
        .ADDR_W    (AW),
        .CNT_W     (XW)
    ) u_word (
        .op        (op_reg),
        .word_idx  (p_word_reg),
        .pos       (pos_reg),
        .span      (span_reg),
        .len       (len_x),
        .new_len   (nlen_reg),
        .old_word  (a_word),
        .prev_word (prev_reg),
        .cur_word  (b_word),
        .new_word  (sweep_word)
    );

    bvire_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NW)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (a_addr),
        .rdata_a (rdata_a),
        .raddr_b (b_addr),
        .rdata_b (rdata_b)
    );

    // Next state, store writes and results.
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        pos_next     = pos_reg;
        span_next    = span_reg;
        nlen_next    = nlen_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        any_next     = any_reg | (p_valid_reg & (|a_word));
        done_next    = 1'b0;
        bit_next     = bit_reg;
        out_len_next = out_len_reg;
        stat_next    = stat_reg;
        we           = 1'b0;
        waddr        = p_word_reg;
        wdata        = sweep_word;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = act;
                    pos_next     = pos_x;
                    span_next    = span_x;
                    nlen_next    = len_x;
                    any_next     = 1'b0;
                    cnt_next     = '0;
                    bit_next     = 1'b0;
                    out_len_next = FIELD_W'(len_reg);
                    stat_next    = STAT_OK;
                    if (rejected)
                    begin
                        done_next = 1'b1;
                        stat_next = STAT_RDONLY;
                    end
                    else
                    begin
                        case (act)
                            ACT_GET, ACT_SET, ACT_UNSET, ACT_TOGGLE:
                            begin
                                if (pos_x >= len_x)
                                begin
                                    done_next = 1'b1;
                                    stat_next = STAT_RANGE;
                                end
                                else
                                begin
                                    state_next = S_BIT;
                                end
                            end
                            ACT_SETALL, ACT_INVERT, ACT_ANY:
                            begin
                                state_next = S_SWEEP;
                            end
                            ACT_REMOVE:
                            begin
                                if (pos_x >= len_x)
                                begin
                                    done_next = 1'b1;
                                    stat_next = STAT_RANGE;
                                end
                                else if (pos_x + span_x > len_x)
                                begin
                                    nlen_next  = pos_x;
                                    state_next = S_SWEEP;
                                end
                                else if (span_x != '0)
                                begin
                                    nlen_next  = len_x - span_x;
                                    state_next = S_SWEEP;
                                end
                                else
                                begin
                                    done_next = 1'b1;
                                end
                            end
                            ACT_INSERT:
                            begin
                                pos_next = pos_min;
                                if (span_x == '0)
                                begin
                                    done_next = 1'b1;
                                end
                                else if (len_x + span_x > XW'(MAX_BITS))
                                begin
                                    done_next = 1'b1;
                                    stat_next = STAT_CAP;
                                end
                                else
                                begin
                                    nlen_next  = len_x + span_x;
                                    state_next = S_SWEEP;
                                end
                            end
                            default:
                            begin
                                done_next = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_BIT:
            begin
                we         = (op_reg != ACT_GET);
                waddr      = reg_word[AW-1:0];
                wdata      = bit_word;
                done_next  = 1'b1;
                bit_next   = (op_reg == ACT_GET) ? old_bit : (new_bit != old_bit);
                state_next = S_IDLE;
            end
            S_SWEEP:
            begin
                we       = p_valid_reg && (op_reg != ACT_ANY);
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(NW - 1))
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                we           = (op_reg != ACT_ANY);
                done_next    = 1'b1;
                bit_next     = (op_reg == ACT_ANY) ? any_next : 1'b0;
                len_next     = nlen_reg[LW-1:0];
                out_len_next = FIELD_W'(nlen_reg);
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            ro_reg      <= 1'b0;
            done_reg    <= 1'b0;
            p_valid_reg <= 1'b0;
            wvalid_reg  <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            done_reg    <= done_next;
            p_valid_reg <= sweep_rd;
            cnt_reg     <= cnt_next;
            if (we)
            begin
                wvalid_reg[waddr] <= 1'b1;
            end
            if (psel && penable && pwrite)
            begin
                ro_reg <= pwdata[0];
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        span_reg    <= span_next;
        nlen_reg    <= nlen_next;
        any_reg     <= any_next;
        bit_reg     <= bit_next;
        out_len_reg <= out_len_next;
        stat_reg    <= stat_next;
        p_word_reg  <= w_issue;
        a_vld_reg   <= wvalid_reg[a_addr];
        b_vld_reg   <= src_ok && wvalid_reg[b_addr];
        prev_reg    <= b_word;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign bit_result = bit_reg;
    assign vec_length = out_len_reg;
    assign status     = stat_reg;
    assign pready     = 1'b1;
    assign prdata     = (paddr == REG_READ_ONLY) ? CFG_DATA_W'(ro_reg) : '0;

`ifndef SYNTHESIS
    // A result strobe never overlaps an action still in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == S_IDLE))
        else $error("result strobe while an action is in progress");

    // Every accepted beat either answers at once or leaves idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted beat produced neither a result nor work");

    // The store is only written while an action is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg != S_IDLE))
        else $error("store written while idle");

    // The valid length never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        XW'(len_reg) <= XW'(MAX_BITS))
        else $error("valid length beyond capacity");
`endif

endmodule
`default_nettype wire
